FILE: sv/bsrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite row blitter package
// Shared widths, register indexes, reset values and the pixel step type.
// ----------------------------------------------------------------------------
package bsrb_pkg;

  localparam int MASK_W     = 64;
  localparam int COORD_W    = 12;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_POS_W  = 10;
  localparam int CHAR_W     = 8;
  localparam int OUT_DATA_W = 32;
  localparam int DIM_W      = 13;
  localparam int CFG_DIM_W  = 11;
  localparam int CFG_SPW_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int DEF_MAX_SPRITE_WIDTH = 64;
  localparam int DEF_MAX_SCREEN_DIM   = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_CHAR       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_CHAR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE     = 3'd5;

  localparam logic [CFG_DIM_W-1:0] RST_SCREEN_WIDTH  = 11'd80;
  localparam logic [CFG_DIM_W-1:0] RST_SCREEN_HEIGHT = 11'd25;
  localparam logic [CFG_SPW_W-1:0] RST_SPRITE_WIDTH  = 7'd8;
  localparam logic [CHAR_W-1:0]    RST_ON_CHAR       = 8'd35;
  localparam logic [CHAR_W-1:0]    RST_OFF_CHAR      = 8'd32;

  typedef struct packed {
    logic                 emit;
    logic                 row_end;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic [CHAR_W-1:0]    chr;
  } pix_step_t;

endpackage

FILE: sv/bsrb_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite row bit scanner
// Shifts out one row mask bit per unstalled cycle, walks the column and clips.
// ----------------------------------------------------------------------------
module bsrb_scan #(
  parameter int MAX_SPRITE_WIDTH = bsrb_pkg::DEF_MAX_SPRITE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 idle,
  input  logic [bsrb_pkg::MASK_W-1:0]          row_bits,
  input  logic [bsrb_pkg::COORD_W-1:0]         screen_row,
  input  logic [bsrb_pkg::COORD_W-1:0]         start_col,
  input  logic [bsrb_pkg::DIM_W-1:0]           scr_w,
  input  logic [bsrb_pkg::DIM_W-1:0]           scr_h,
  input  logic [bsrb_pkg::CFG_SPW_W-1:0]       spr_w,
  input  logic [bsrb_pkg::CHAR_W-1:0]          on_char,
  input  logic [bsrb_pkg::CHAR_W-1:0]          off_char,
  input  logic                                 draw_mode,
  input  logic                                 step_ready,
  output bsrb_pkg::pix_step_t                  step
);
  import bsrb_pkg::*;

  localparam int IDX_W = (MAX_SPRITE_WIDTH > 1) ? $clog2(MAX_SPRITE_WIDTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } scan_state_t;

  scan_state_t                 state_r, state_nxt;
  logic [MAX_SPRITE_WIDTH-1:0] mask_r, mask_nxt;
  logic [CFG_SPW_W-1:0]        cnt_r, cnt_nxt;
  logic [COORD_W:0]            col_r, col_nxt;
  logic [OUT_POS_W-1:0]        row_r, row_nxt;
  logic [CFG_SPW_W-1:0]        w_eff;
  logic [CFG_SPW_W-1:0]        w_m1;
  logic                        bit_cur;
  logic                        col_in;
  logic                        row_in;

  assign w_eff = (spr_w > CFG_SPW_W'(MAX_SPRITE_WIDTH)) ? CFG_SPW_W'(MAX_SPRITE_WIDTH) : spr_w;
  assign w_m1    = w_eff - 1'b1;
  assign bit_cur = mask_r[w_m1[IDX_W-1:0]];
  assign col_in  = !col_r[COORD_W] && ({1'b0, col_r[COORD_W-1:0]} < scr_w);
  assign row_in  = !screen_row[COORD_W-1]
                   && ({2'b00, screen_row[COORD_W-2:0]} < scr_h);
  assign idle    = (state_r == ST_IDLE);

  always_comb begin
    step         = '0;
    step.row     = row_r;
    step.col     = col_r[OUT_POS_W-1:0];
    step.chr     = (draw_mode && bit_cur) ? off_char : on_char;
    step.emit    = (state_r == ST_SCAN) && col_in && (draw_mode || bit_cur);
    step.row_end = (state_r == ST_FLUSH);
  end

  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mask_nxt  = row_bits[MAX_SPRITE_WIDTH-1:0];
          cnt_nxt   = w_eff;
          col_nxt   = {start_col[COORD_W-1], start_col};
          row_nxt   = screen_row[OUT_POS_W-1:0];
          state_nxt = (row_in && (w_eff != '0)) ? ST_SCAN : ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (step_ready) begin
          mask_nxt = mask_r << 1;
          col_nxt  = col_r + 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
          if (cnt_r == CFG_SPW_W'(1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (step_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    cnt_r  <= cnt_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
  end

endmodule

FILE: sv/bsrb_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite row write buffer
// Holds back one write until the next one or the row end shows whether it
// is the last of its row, then presents it on the output register.
// ----------------------------------------------------------------------------
module bsrb_outbuf (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bsrb_pkg::pix_step_t                  step,
  output logic                                 step_ready,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bsrb_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);
  import bsrb_pkg::*;

  logic                 pend_v_r, pend_v_nxt;
  logic [OUT_POS_W-1:0] pend_row_r, pend_row_nxt;
  logic [OUT_POS_W-1:0] pend_col_r, pend_col_nxt;
  logic [CHAR_W-1:0]    pend_chr_r, pend_chr_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [OUT_POS_W-1:0] out_row_r, out_row_nxt;
  logic [OUT_POS_W-1:0] out_col_r, out_col_nxt;
  logic [CHAR_W-1:0]    out_chr_r, out_chr_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_free;
  logic                 fire;

  assign out_free   = !out_v_r || out_tready;
  assign step_ready = !pend_v_r || out_free;
  assign fire       = step_ready && (step.emit || step.row_end);

  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_row_nxt = pend_row_r;
    pend_col_nxt = pend_col_r;
    pend_chr_nxt = pend_chr_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_chr_nxt  = out_chr_r;
    out_last_nxt = out_last_r;
    if (fire) begin
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_row_nxt  = pend_row_r;
        out_col_nxt  = pend_col_r;
        out_chr_nxt  = pend_chr_r;
        out_last_nxt = step.row_end;
      end
      pend_v_nxt = step.emit;
      if (step.emit) begin
        pend_row_nxt = step.row;
        pend_col_nxt = step.col;
        pend_chr_nxt = step.chr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    pend_chr_r <= pend_chr_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_chr_r  <= out_chr_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 * OUT_POS_W - CHAR_W){1'b0}},
                       out_chr_r, out_col_r, out_row_r};

endmodule

FILE: sv/bitmask_sprite_row_blitter.sv
`timescale 1ns / 1ps
// A row is accepted, then scanned for the sprite width, one mask bit per
// cycle while the output does not stall, then closed; its last write is held
// in the write buffer until the row end, then registered at the output.
// A new row is accepted only while the bit scanner is idle; a row off the
// screen vertically or of zero width is closed without a scan.
// Reset: synchronous, active low; control registers return to their defaults.
// ----------------------------------------------------------------------------
// Bitmask sprite row blitter
// Turns one-bit sprite rows into clipped character framebuffer writes.
// ----------------------------------------------------------------------------
module bitmask_sprite_row_blitter #(
  parameter int MAX_SPRITE_WIDTH = bsrb_pkg::DEF_MAX_SPRITE_WIDTH,
  parameter int MAX_SCREEN_DIM   = bsrb_pkg::DEF_MAX_SCREEN_DIM
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // row_bits[63:0], screen_row[75:64], start_col[87:76]
  input  logic [bsrb_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_row[9:0], out_col[19:10], out_char[27:20], zero fill above
  output logic [bsrb_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bsrb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsrb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bsrb_pkg::*;

  logic [CFG_DIM_W-1:0] scr_w_r;
  logic [CFG_DIM_W-1:0] scr_h_r;
  logic [CFG_SPW_W-1:0] spr_w_r;
  logic [CHAR_W-1:0]    on_char_r;
  logic [CHAR_W-1:0]    off_char_r;
  logic                 mode_r;
  logic [DIM_W-1:0]     scr_w_sat;
  logic [DIM_W-1:0]     scr_h_sat;
  logic                 scan_idle;
  logic                 step_ready;
  pix_step_t            step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r    <= RST_SCREEN_WIDTH;
      scr_h_r    <= RST_SCREEN_HEIGHT;
      spr_w_r    <= RST_SPRITE_WIDTH;
      on_char_r  <= RST_ON_CHAR;
      off_char_r <= RST_OFF_CHAR;
      mode_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_r    <= cfg_data;
        REG_SCREEN_HEIGHT: scr_h_r    <= cfg_data;
        REG_SPRITE_WIDTH:  spr_w_r    <= cfg_data[CFG_SPW_W-1:0];
        REG_ON_CHAR:       on_char_r  <= cfg_data[CHAR_W-1:0];
        REG_OFF_CHAR:      off_char_r <= cfg_data[CHAR_W-1:0];
        REG_DRAW_MODE:     mode_r     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign scr_w_sat = (DIM_W'(scr_w_r) > DIM_W'(MAX_SCREEN_DIM)) ? DIM_W'(MAX_SCREEN_DIM)
                                                                 : DIM_W'(scr_w_r);
  assign scr_h_sat = (DIM_W'(scr_h_r) > DIM_W'(MAX_SCREEN_DIM)) ? DIM_W'(MAX_SCREEN_DIM)
                                                                 : DIM_W'(scr_h_r);

  assign in_tready = scan_idle;

  bsrb_scan #(
    .MAX_SPRITE_WIDTH(MAX_SPRITE_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid),
    .idle      (scan_idle),
    .row_bits  (in_tdata[MASK_W-1:0]),
    .screen_row(in_tdata[MASK_W+COORD_W-1:MASK_W]),
    .start_col (in_tdata[MASK_W+2*COORD_W-1:MASK_W+COORD_W]),
    .scr_w     (scr_w_sat),
    .scr_h     (scr_h_sat),
    .spr_w     (spr_w_r),
    .on_char   (on_char_r),
    .off_char  (off_char_r),
    .draw_mode (mode_r),
    .step_ready(step_ready),
    .step      (step)
  );

  bsrb_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .step_ready(step_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
